// File: hdl/csvtok_pkg.sv
// csvtok_pkg: shared constants, codes and the result record of the csv line tokenizer
// depends on nothing; used by hdl/csv_line_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

package csvtok_pkg;

	// most fields extracted per line, caps the configured limit
	localparam logic [4:0] MAX_FIELDS = 5'd16;
	// fields at or past this index are always string columns
	localparam int MASK_W = 16;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0a;
	localparam logic [7:0] PLUS_BYTE    = 8'h2b;
	localparam logic [7:0] MINUS_BYTE   = 8'h2d;
	localparam logic [7:0] ZERO_BYTE    = 8'h30;
	localparam logic [7:0] NINE_BYTE    = 8'h39;
	localparam logic [7:0] SPACE_BYTE   = 8'h20;
	localparam logic [7:0] TAB_BYTE     = 8'h09;
	localparam logic [7:0] CR_BYTE      = 8'h0d;

	localparam logic [7:0]  SEPARATOR_RESET = 8'd59;
	localparam logic [15:0] INT_MASK_RESET  = 16'h0000;
	localparam logic [4:0]  LIMIT_RESET     = 5'd16;

	// magnitude ceiling of the integer parser and the positive clamp
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] INT_MAX   = 32'h7fff_ffff;

	// result queue, depth a power of two so the pointers wrap
	localparam int MAX_RES   = 3;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEPARATOR   = 2'd0,
		CFG_INT_MASK    = 2'd1,
		CFG_FIELD_LIMIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_INT  = 2'd1,
		KIND_STR  = 2'd2,
		KIND_LINE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_STOP   = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         field_index;
		logic [7:0]         char_out;
		logic signed [31:0] int_value;
		logic [4:0]         field_count;
		logic               run_last;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/csv_line_tokenizer.sv
// csv_line_tokenizer: splits a byte stream into lines and fields, parses integer columns
// depends on hdl/csvtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in        to block   in_valid / in_stall    data_byte, buffer_end
// out       from block out_valid / out_stall  kind, field_index, char_out, int_value,
//                                             field_count, run_last
// cfg       to block   cfg_we                 cfg_index, cfg_data
//
// a byte is registered in stage s1, then decoded against the line state in one pass
// that yields up to three results, which drop into a four-entry result queue
// one byte per cycle while each byte gives at most one result and out_stall is low; the
// queue drains one result per cycle while out_stall is low, so a byte with two or three
// results is absorbed until the four queue entries are taken up
// the first result of a request passes stage s1 and the result queue before it is offered
// reset puts the registers at their defaults, clears the line state and empties the queue
// out_stall only fills the queue; the input stalls once the queued results leave no room

module csv_line_tokenizer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input requests
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             buffer_end,
	// result requests
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [1:0]                            kind,
	output logic [3:0]                            field_index,
	output logic [7:0]                            char_out,
	output logic signed [31:0]                    int_value,
	output logic [4:0]                            field_count,
	output logic                                  run_last,
	// configuration writes
	input  wire logic                             cfg_we,
	input  wire logic [csvtok_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csvtok_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [7:0]  separator_q;
	logic [15:0] int_mask_q;
	logic [4:0]  field_limit_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// line and field state
	logic               [4:0]  fn_q;
	logic                      fhb_q;
	csvtok_pkg::phase_t        ph_q;
	logic                      neg_q;
	logic               [31:0] acc_q;

	// result queue
	csvtok_pkg::res_t                    q_mem [csvtok_pkg::QDEPTH];
	logic [csvtok_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [csvtok_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [csvtok_pkg::QCNT_W-1:0]       cnt_q;
	csvtok_pkg::res_t                    head;

	// decode signals
	logic [4:0]         eff_lim;
	logic               is_nl;
	logic               is_sep;
	logic               line_end;
	logic               is_digit;
	logic               is_ws;
	logic [35:0]        prod;
	logic [31:0]        acc_dig;
	csvtok_pkg::phase_t ph_p;
	logic               neg_p;
	logic [31:0]        acc_p;
	logic [4:0]         fn_m;
	logic               fhb_m;
	csvtok_pkg::phase_t ph_m;
	logic               neg_m;
	logic [31:0]        acc_m;
	logic [4:0]         fn_l;
	logic [4:0]         fn_n;
	logic               fhb_n;
	csvtok_pkg::phase_t ph_n;
	logic               neg_n;
	logic [31:0]        acc_n;

	csvtok_pkg::res_t                 res   [csvtok_pkg::MAX_RES];
	logic [csvtok_pkg::MAX_RES-1:0]   res_v;
	csvtok_pkg::res_t                 cmp   [csvtok_pkg::MAX_RES];
	logic [csvtok_pkg::RES_CNT_W-1:0] nres;

	// handshake and queue control
	logic                              pop;
	logic                              advance;
	logic                              accept;
	logic [csvtok_pkg::QCNT_W:0]       cnt_after;
	logic [csvtok_pkg::RES_CNT_W-1:0]  push_n;

	// integer column test, fields past the mask are strings
	function automatic logic int_col(input logic [4:0] k, input logic [15:0] mask);
		logic r;
		r = (k < 5'(csvtok_pkg::MASK_W)) && mask[k[3:0]];
		return r;
	endfunction

	// result that closes field k with the given parser state
	function automatic csvtok_pkg::res_t close_res(input logic [4:0] k, input logic [15:0] mask,
			input logic neg, input logic [31:0] acc);
		csvtok_pkg::res_t r;
		r = '0;
		r.field_index = k[3:0];
		if (int_col(k, mask)) begin
			r.kind = csvtok_pkg::KIND_INT;
			if (neg) begin
				r.int_value = 32'd0 - acc;
			end else if (acc >= csvtok_pkg::MAG_LIMIT) begin
				r.int_value = csvtok_pkg::INT_MAX;
			end else begin
				r.int_value = acc;
			end
		end else begin
			r.kind = csvtok_pkg::KIND_STR;
		end
		return r;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q   <= csvtok_pkg::SEPARATOR_RESET;
			int_mask_q    <= csvtok_pkg::INT_MASK_RESET;
			field_limit_q <= csvtok_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csvtok_pkg::CFG_SEPARATOR:   separator_q   <= cfg_data[7:0];
				csvtok_pkg::CFG_INT_MASK:    int_mask_q    <= cfg_data[15:0];
				csvtok_pkg::CFG_FIELD_LIMIT: field_limit_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// one pass over the byte in s1: field split, integer parse, line end
	always_comb begin
		eff_lim  = (field_limit_q > csvtok_pkg::MAX_FIELDS) ? csvtok_pkg::MAX_FIELDS
			: field_limit_q;
		is_nl    = byte_s1 == csvtok_pkg::NEWLINE_BYTE;
		is_sep   = byte_s1 == separator_q;
		line_end = is_nl || last_s1;
		is_digit = (byte_s1 >= csvtok_pkg::ZERO_BYTE) && (byte_s1 <= csvtok_pkg::NINE_BYTE);
		is_ws    = (byte_s1 == csvtok_pkg::SPACE_BYTE)
			|| ((byte_s1 >= csvtok_pkg::TAB_BYTE) && (byte_s1 <= csvtok_pkg::CR_BYTE));

		// acc * 10 + digit, clamped at 2^31
		prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
			+ 36'(byte_s1[3:0]);
		acc_dig = (prod > 36'(csvtok_pkg::MAG_LIMIT)) ? csvtok_pkg::MAG_LIMIT : prod[31:0];

		ph_p  = ph_q;
		neg_p = neg_q;
		acc_p = acc_q;
		if (ph_q == csvtok_pkg::PH_LEAD && is_ws) begin
			ph_p = ph_q;
		end else if (ph_q == csvtok_pkg::PH_LEAD && byte_s1 == csvtok_pkg::PLUS_BYTE) begin
			ph_p = csvtok_pkg::PH_DIGITS;
		end else if (ph_q == csvtok_pkg::PH_LEAD && byte_s1 == csvtok_pkg::MINUS_BYTE) begin
			ph_p  = csvtok_pkg::PH_DIGITS;
			neg_p = 1'b1;
		end else if (ph_q != csvtok_pkg::PH_STOP && is_digit) begin
			ph_p  = csvtok_pkg::PH_DIGITS;
			acc_p = acc_dig;
		end else begin
			ph_p = csvtok_pkg::PH_STOP;
		end

		for (int i = 0; i < csvtok_pkg::MAX_RES; i++) begin
			res[i] = '0;
		end
		res_v = '0;

		fn_m  = fn_q;
		fhb_m = fhb_q;
		ph_m  = ph_q;
		neg_m = neg_q;
		acc_m = acc_q;
		if (!is_nl) begin
			if (is_sep) begin
				if (fn_q < eff_lim) begin
					res[0]   = close_res(fn_q, int_mask_q, neg_q, acc_q);
					res_v[0] = 1'b1;
					fn_m     = fn_q + 5'd1;
					fhb_m    = 1'b0;
					ph_m     = csvtok_pkg::PH_LEAD;
					neg_m    = 1'b0;
					acc_m    = '0;
				end
			end else if (fn_q < eff_lim) begin
				fhb_m = 1'b1;
				if (int_col(fn_q, int_mask_q)) begin
					ph_m  = ph_p;
					neg_m = neg_p;
					acc_m = acc_p;
				end else begin
					res[0].kind        = csvtok_pkg::KIND_CHAR;
					res[0].field_index = fn_q[3:0];
					res[0].char_out    = byte_s1;
					res_v[0]           = 1'b1;
				end
			end
		end

		// line end: close a nonempty last field, then report the count
		fn_l = fn_m;
		if (line_end) begin
			if (fhb_m && fn_m < eff_lim) begin
				res[1]   = close_res(fn_m, int_mask_q, neg_m, acc_m);
				res_v[1] = 1'b1;
				fn_l     = fn_m + 5'd1;
			end
			res[2].kind        = csvtok_pkg::KIND_LINE;
			res[2].field_count = fn_l;
			res_v[2]           = 1'b1;
			fn_n  = '0;
			fhb_n = 1'b0;
			ph_n  = csvtok_pkg::PH_LEAD;
			neg_n = 1'b0;
			acc_n = '0;
		end else begin
			fn_n  = fn_m;
			fhb_n = fhb_m;
			ph_n  = ph_m;
			neg_n = neg_m;
			acc_n = acc_m;
		end

		// mark the last result of the byte
		for (int i = 0; i < csvtok_pkg::MAX_RES; i++) begin
			res[i].run_last = res_v[i] && ((res_v >> (i + 1)) == '0);
		end

		// pack valid results to the front
		for (int i = 0; i < csvtok_pkg::MAX_RES; i++) begin
			cmp[i] = '0;
		end
		nres = '0;
		for (int i = 0; i < csvtok_pkg::MAX_RES; i++) begin
			if (res_v[i]) begin
				cmp[nres[csvtok_pkg::RES_IDX_W-1:0]] = res[i];
				nres = nres + 1'b1;
			end
		end
	end

	// queue room: what remains after this cycle's pop must take every result of the byte
	assign pop       = out_valid && !out_stall;
	assign cnt_after = {1'b0, cnt_q} - (csvtok_pkg::QCNT_W + 1)'(pop)
		+ (csvtok_pkg::QCNT_W + 1)'(nres);
	assign advance   = valid_s1 && (cnt_after <= (csvtok_pkg::QCNT_W + 1)'(csvtok_pkg::QDEPTH));
	assign push_n    = advance ? nres : '0;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= buffer_end;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_q  <= '0;
			fhb_q <= 1'b0;
			ph_q  <= csvtok_pkg::PH_LEAD;
			neg_q <= 1'b0;
			acc_q <= '0;
		end else if (advance) begin
			fn_q  <= fn_n;
			fhb_q <= fhb_n;
			ph_q  <= ph_n;
			neg_q <= neg_n;
			acc_q <= acc_n;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + csvtok_pkg::QPTR_W'(pop);
			wr_ptr_q <= wr_ptr_q + csvtok_pkg::QPTR_W'(push_n);
			cnt_q    <= cnt_q - csvtok_pkg::QCNT_W'(pop) + csvtok_pkg::QCNT_W'(push_n);
		end
	end

	// entry e takes packed result (e - wr_ptr)
	always_ff @(posedge clk) begin
		for (int e = 0; e < csvtok_pkg::QDEPTH; e++) begin
			if (csvtok_pkg::QPTR_W'(csvtok_pkg::QPTR_W'(e) - wr_ptr_q)
					< csvtok_pkg::QPTR_W'(push_n)) begin
				q_mem[e] <= cmp[csvtok_pkg::RES_IDX_W'(
					csvtok_pkg::QPTR_W'(csvtok_pkg::QPTR_W'(e) - wr_ptr_q))];
			end
		end
	end

	assign head        = q_mem[rd_ptr_q];
	assign out_valid   = cnt_q != '0;
	assign kind        = head.kind;
	assign field_index = head.field_index;
	assign char_out    = head.char_out;
	assign int_value   = head.int_value;
	assign field_count = head.field_count;
	assign run_last    = head.run_last;

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= csvtok_pkg::QCNT_W'(csvtok_pkg::QDEPTH))
		else $error("result queue over capacity");

	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fn_q <= csvtok_pkg::MAX_FIELDS)
		else $error("field number past the field cap");

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && line_end |=> fn_q == '0 && !fhb_q)
		else $error("line state not cleared at line end");

	a_line_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && line_end |-> res_v[csvtok_pkg::MAX_RES-1] && nres != '0)
		else $error("line end without a line done result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled byte lost from stage s1");
`endif

endmodule

`default_nettype wire
